// File: hdl/srfp_pkg.sv
// srfp_pkg: types, constants and the relocation descriptor table shared by the
// SPARC relocation field patch modules. Depends on nothing.
package srfp_pkg;

	localparam int WordBits = 32;
	localparam int NumTypes = 46;

	typedef logic [WordBits-1:0] word_t;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_UNIMPL  = 3'd1;
	localparam logic [2:0] ST_ALIGN   = 3'd2;
	localparam logic [2:0] ST_LOOSE   = 3'd3;
	localparam logic [2:0] ST_NOFIT   = 3'd4;

	// descriptor flags
	localparam logic [4:0] F_SIGN = 5'b00001;
	localparam logic [4:0] F_VER  = 5'b00010;
	localparam logic [4:0] F_UNAL = 5'b00100;
	localparam logic [4:0] F_WD16 = 5'b01000;
	localparam logic [4:0] F_LO10 = 5'b10000;

	// unit sizes in bytes
	localparam logic [2:0] UNIT_NONE = 3'd0;
	localparam logic [2:0] UNIT_BYTE = 3'd1;
	localparam logic [2:0] UNIT_HALF = 3'd2;
	localparam logic [2:0] UNIT_WORD = 3'd4;

	// WDISP16 split field layout
	localparam word_t Wd16HiMask   = 32'h0030_0000;
	localparam word_t Wd16LoMask   = 32'h0000_3fff;
	localparam word_t Wd16KeepMask = ~32'h0030_3fff;
	localparam word_t Wd16TopMask  = 32'h0000_c000;
	localparam word_t Lo10Mask     = 32'h0000_03ff;
	localparam word_t LowTwoMask   = 32'h0000_0003;

	typedef struct packed {
		logic [5:0]  reloc_type;
		logic [31:0] place_word;
		logic [1:0]  place_addr_low;
		logic [31:0] add_value;
	} in_t;

	typedef struct packed {
		logic [31:0] patched_word;
		logic [31:0] shifted_value;
		logic [2:0]  status;
	} out_t;

	typedef struct packed {
		logic [2:0] bytes;
		logic [4:0] flags;
		logic [3:0] shift;
		logic [4:0] width;
	} desc_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [2:0] status;   // ST_OK, ST_UNIMPL or ST_ALIGN
		desc_t      desc;
		word_t      unit;     // place word masked to the unit
		word_t      keep;     // unit bits outside the field
		word_t      field_sh; // extracted, extended, shifted field
		word_t      add_value;
	} work_t;

	function automatic desc_t mk(input logic [2:0] b, input logic [4:0] f,
			input logic [3:0] s, input logic [4:0] w);
		desc_t d;
		d.bytes = b;
		d.flags = f;
		d.shift = s;
		d.width = w;
		return d;
	endfunction

	function automatic desc_t lookup(input logic [5:0] t);
		desc_t d;
		unique case (t)
			6'd1:  d = mk(UNIT_BYTE, F_VER, 4'd0, 5'd0);
			6'd2:  d = mk(UNIT_HALF, F_VER, 4'd0, 5'd0);
			6'd3:  d = mk(UNIT_WORD, F_VER, 4'd0, 5'd0);
			6'd4:  d = mk(UNIT_BYTE, F_VER | F_SIGN, 4'd0, 5'd0);
			6'd5:  d = mk(UNIT_HALF, F_VER | F_SIGN, 4'd0, 5'd0);
			6'd6:  d = mk(UNIT_WORD, F_VER | F_SIGN, 4'd0, 5'd0);
			6'd7:  d = mk(UNIT_WORD, F_VER | F_SIGN, 4'd2, 5'd30);
			6'd8:  d = mk(UNIT_WORD, F_VER | F_SIGN, 4'd2, 5'd22);
			6'd9:  d = mk(UNIT_WORD, 5'd0, 4'd10, 5'd22);
			6'd10: d = mk(UNIT_WORD, F_VER, 4'd0, 5'd22);
			6'd11: d = mk(UNIT_WORD, F_VER | F_SIGN, 4'd0, 5'd13);
			6'd12: d = mk(UNIT_WORD, F_SIGN | F_LO10, 4'd0, 5'd13);
			6'd13: d = mk(UNIT_WORD, F_SIGN | F_LO10, 4'd0, 5'd13);
			6'd14: d = mk(UNIT_WORD, F_VER | F_SIGN, 4'd0, 5'd13);
			6'd15: d = mk(UNIT_WORD, 5'd0, 4'd10, 5'd22);
			6'd16: d = mk(UNIT_WORD, F_SIGN | F_LO10, 4'd0, 5'd13);
			6'd17: d = mk(UNIT_WORD, F_VER | F_SIGN, 4'd10, 5'd22);
			6'd18: d = mk(UNIT_WORD, F_VER | F_SIGN, 4'd2, 5'd30);
			6'd20: d = mk(UNIT_WORD, 5'd0, 4'd0, 5'd0);
			6'd22: d = mk(UNIT_WORD, 5'd0, 4'd0, 5'd0);
			6'd23: d = mk(UNIT_WORD, F_UNAL, 4'd0, 5'd0);
			6'd24: d = mk(UNIT_WORD, F_VER, 4'd0, 5'd0);
			6'd25: d = mk(UNIT_WORD, 5'd0, 4'd10, 5'd22);
			6'd26: d = mk(UNIT_WORD, F_LO10, 4'd0, 5'd13);
			6'd27: d = mk(UNIT_WORD, F_VER, 4'd0, 5'd0);
			6'd28: d = mk(UNIT_WORD, F_VER, 4'd10, 5'd22);
			6'd29: d = mk(UNIT_WORD, F_VER | F_LO10, 4'd0, 5'd12);
			6'd30: d = mk(UNIT_WORD, F_VER | F_SIGN, 4'd0, 5'd10);
			6'd31: d = mk(UNIT_WORD, F_VER | F_SIGN, 4'd0, 5'd11);
			6'd40: d = mk(UNIT_WORD, F_VER | F_SIGN | F_WD16, 4'd2, 5'd16);
			6'd41: d = mk(UNIT_WORD, F_VER | F_SIGN, 4'd2, 5'd19);
			6'd43: d = mk(UNIT_WORD, 5'd0, 4'd0, 5'd7);
			6'd44: d = mk(UNIT_WORD, 5'd0, 4'd0, 5'd5);
			6'd45: d = mk(UNIT_WORD, 5'd0, 4'd0, 5'd6);
			default: d = mk(UNIT_NONE, 5'd0, 4'd0, 5'd0);
		endcase
		return d;
	endfunction

	function automatic word_t field_mask(input logic [4:0] w);
		word_t m;
		m = (w == 5'd0) ? '0 : ((word_t'(1) << w) - word_t'(1));
		return m;
	endfunction

	function automatic word_t unit_mask(input logic [2:0] b);
		word_t m;
		if (b == UNIT_BYTE) begin
			m = 32'h0000_00ff;
		end else if (b == UNIT_HALF) begin
			m = 32'h0000_ffff;
		end else begin
			m = '1;
		end
		return m;
	endfunction

endpackage

// File: hdl/sparc_relocation_field_patch.sv
// sparc_relocation_field_patch: top level of the SPARC ELF relocation field patcher.
// Depends on srfp_pkg, srfp_front, srfp_queue and srfp_back.
//
// One relocation per item: the type selects a descriptor from a fixed 46-entry table
// (unit size, shift, field width, signed/verify/unaligned/WDISP16/LO10 flags). The
// block pulls the field out of place_word, sign-extends and shifts it, adds add_value,
// checks low bits and fit, and merges the field back. Each item gives exactly one
// result: patched_word, shifted_value and status (0 ok, 1 unimplemented type,
// 2 misaligned place, 3 loose low bits, 4 value does not fit). On any error the
// unit comes back unchanged and shifted_value is add_value as given. Types 46..63
// report status 1. Throughput is one item per clock when the output side is not
// stalled; an accepted item passes the queue, then the output register. The front
// part (lookup, classification, extraction) writes straight into a QUEUE_DEPTH-entry
// queue; the back part (add, checks, merge) drains it into the output register, so
// a stalled consumer holds off the input only once the queue fills.
module sparc_relocation_field_patch #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  srfp_pkg::in_t  in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output srfp_pkg::out_t out_item
);

	srfp_pkg::work_t front_work;
	srfp_pkg::work_t q_head;
	logic            q_full;
	logic            q_not_empty;
	logic            back_take;
	logic            in_take;

	// input side only waits on queue space, never on the output
	assign in_ready = !q_full;
	assign in_take  = in_valid && in_ready;

	srfp_front u_front (
		.item (in_item),
		.work (front_work)
	);

	srfp_queue #(
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_take),
		.push_data (front_work),
		.full      (q_full),
		.pop       (back_take),
		.not_empty (q_not_empty),
		.pop_data  (q_head)
	);

	srfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_valid (q_not_empty),
		.work       (q_head),
		.work_take  (back_take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule

// File: hdl/srfp_front.sv
// srfp_front: table lookup, place check, field extraction and pre-shift.
// Depends on srfp_pkg.
module srfp_front (
	input  srfp_pkg::in_t   item,
	output srfp_pkg::work_t work
);

	srfp_pkg::desc_t d;
	srfp_pkg::word_t unit, smask, fmask, fld;

	always_comb begin
		d     = srfp_pkg::lookup(item.reloc_type);
		unit  = item.place_word & srfp_pkg::unit_mask(d.bytes);
		smask = srfp_pkg::field_mask(d.width);
		fmask = smask;
		if (((d.flags & srfp_pkg::F_SIGN) != '0) && (smask != '0)) begin
			fmask = srfp_pkg::field_mask(d.width - 5'd1);
		end

		work.status = srfp_pkg::ST_OK;
		if (d.bytes == srfp_pkg::UNIT_NONE) begin
			work.status = srfp_pkg::ST_UNIMPL;
		end else if (((d.flags & srfp_pkg::F_UNAL) == '0) &&
				(((d.bytes == srfp_pkg::UNIT_HALF) && item.place_addr_low[0]) ||
				((d.bytes == srfp_pkg::UNIT_WORD) && (item.place_addr_low != 2'd0)))) begin
			work.status = srfp_pkg::ST_ALIGN;
		end

		work.keep = unit;
		fld       = unit;
		if (smask != '0) begin
			if ((d.flags & srfp_pkg::F_WD16) != '0) begin
				fld = ((unit & srfp_pkg::Wd16HiMask) >> 6) | (unit & srfp_pkg::Wd16LoMask);
				work.keep = unit & srfp_pkg::Wd16KeepMask;
			end else begin
				fld = unit & smask;
				work.keep = unit & ~smask;
			end
			// sign bit of the field is the one bit in smask but not in fmask
			if (((d.flags & srfp_pkg::F_SIGN) != '0) && ((fld & smask & ~fmask) != '0)) begin
				fld = fld | ~smask;
			end
		end

		work.desc      = d;
		work.unit      = unit;
		work.field_sh  = fld << d.shift;
		work.add_value = item.add_value;
	end

endmodule

// File: hdl/srfp_queue.sv
// srfp_queue: small register FIFO of classified items between front and back.
// Depends on srfp_pkg.
module srfp_queue #(
	parameter int Depth = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  srfp_pkg::work_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output srfp_pkg::work_t pop_data
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	srfp_pkg::work_t   mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		logic [PtrW-1:0] n;
		n = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// File: hdl/srfp_back.sv
// srfp_back: add, loose-bit and fit checks, field merge, output register.
// Depends on srfp_pkg.
module srfp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            work_valid,
	input  srfp_pkg::work_t work,
	output logic            work_take,
	output logic            out_valid,
	input  logic            out_ready,
	output srfp_pkg::out_t  out_item
);

	srfp_pkg::out_t  res;
	srfp_pkg::out_t  out_q;
	logic            out_valid_q;
	srfp_pkg::word_t sum, u, core, smask, half, merged;
	logic            fits;

	always_comb begin
		smask = srfp_pkg::field_mask(work.desc.width);
		half  = (work.desc.width == 5'd0) ? '0 : (srfp_pkg::word_t'(1) << (work.desc.width - 5'd1));
		sum   = work.field_sh + work.add_value;
		u     = srfp_pkg::word_t'($signed(sum) >>> work.desc.shift);
		core  = work.add_value >> work.desc.shift;
		if ((work.desc.flags & srfp_pkg::F_LO10) != '0) begin
			u = u & srfp_pkg::Lo10Mask;
		end

		fits = 1'b1;
		if (((work.desc.flags & srfp_pkg::F_VER) != '0) && (smask != '0)) begin
			if ((work.desc.flags & srfp_pkg::F_SIGN) != '0) begin
				fits = ((u + half) <= smask);
			end else begin
				fits = ((u & smask) == u);
			end
		end

		merged = u;
		if (smask != '0) begin
			if ((work.desc.flags & srfp_pkg::F_WD16) != '0) begin
				merged = ((u & srfp_pkg::Wd16TopMask) << 6) | (u & srfp_pkg::Wd16LoMask);
			end else begin
				merged = u & smask;
			end
			merged = merged | work.keep;
		end

		// error results carry the unit unchanged and the amount unshifted
		res.patched_word  = work.unit;
		res.shifted_value = work.add_value;
		res.status        = work.status;
		if (work.status == srfp_pkg::ST_OK) begin
			if ((work.desc.shift == 4'd2) && ((sum & srfp_pkg::LowTwoMask) != '0)) begin
				res.status = srfp_pkg::ST_LOOSE;
			end else if (!fits) begin
				res.status = srfp_pkg::ST_NOFIT;
			end else begin
				res.patched_word  = merged & srfp_pkg::unit_mask(work.desc.bytes);
				res.shifted_value = core;
			end
		end
	end

	assign work_take = work_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk) begin
		if (work_take) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (work_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: hdl/srfp_checker.sv
// srfp_checker: port-level checks of the relocation patcher, bound to the top level.
// Depends on srfp_pkg and sparc_relocation_field_patch.
module srfp_checker #(
	parameter int QueueDepth = 2
) (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input srfp_pkg::out_t out_item
);

	logic [7:0] pending_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 8'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 8'd1;
		end
	end

	// no result without an item behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_q != 8'd0))
		else $error("result shown with no item outstanding");

	// never more in flight than queue plus output register
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 8'(QueueDepth + 1)) |-> !in_ready)
		else $error("input taken while queue and output are full");

	// an item accepted by an idle block passes the queue and the output register to out_valid
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && pending_q == 8'd0 && !out_valid) |=> ##1 out_valid)
		else $error("result late on an idle block");

	// stalled result is held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
		else $error("stalled result changed");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status != srfp_pkg::ST_OK) |->
			(out_item.status == srfp_pkg::ST_UNIMPL || out_item.status == srfp_pkg::ST_ALIGN ||
			out_item.status == srfp_pkg::ST_LOOSE || out_item.status == srfp_pkg::ST_NOFIT))
		else $error("status code out of range");

endmodule

bind sparc_relocation_field_patch srfp_checker #(
	.QueueDepth (QUEUE_DEPTH)
) u_srfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for sparc_relocation_field_patch, driving relocation
// items through the valid/ready ports. Depends on srfp_pkg and the block's RTL.
module testbench;

	// SPARC ABI relocation type numbers used by the descriptor table and the tests
	localparam logic [5:0] R_NONE     = 6'd0;
	localparam logic [5:0] R_8        = 6'd1;
	localparam logic [5:0] R_16       = 6'd2;
	localparam logic [5:0] R_32       = 6'd3;
	localparam logic [5:0] R_DISP8    = 6'd4;
	localparam logic [5:0] R_DISP16   = 6'd5;
	localparam logic [5:0] R_DISP32   = 6'd6;
	localparam logic [5:0] R_WDISP30  = 6'd7;
	localparam logic [5:0] R_WDISP22  = 6'd8;
	localparam logic [5:0] R_HI22     = 6'd9;
	localparam logic [5:0] R_22       = 6'd10;
	localparam logic [5:0] R_13       = 6'd11;
	localparam logic [5:0] R_LO10     = 6'd12;
	localparam logic [5:0] R_GOT10    = 6'd13;
	localparam logic [5:0] R_GOT13    = 6'd14;
	localparam logic [5:0] R_GOT22    = 6'd15;
	localparam logic [5:0] R_PC10     = 6'd16;
	localparam logic [5:0] R_PC22     = 6'd17;
	localparam logic [5:0] R_WPLT30   = 6'd18;
	localparam logic [5:0] R_COPY     = 6'd19;
	localparam logic [5:0] R_GLOB_DAT = 6'd20;
	localparam logic [5:0] R_JMP_SLOT = 6'd21;
	localparam logic [5:0] R_RELATIVE = 6'd22;
	localparam logic [5:0] R_UA32     = 6'd23;
	localparam logic [5:0] R_PLT32    = 6'd24;
	localparam logic [5:0] R_HIPLT22  = 6'd25;
	localparam logic [5:0] R_LOPLT10  = 6'd26;
	localparam logic [5:0] R_PCPLT32  = 6'd27;
	localparam logic [5:0] R_PCPLT22  = 6'd28;
	localparam logic [5:0] R_PCPLT10  = 6'd29;
	localparam logic [5:0] R_10       = 6'd30;
	localparam logic [5:0] R_11       = 6'd31;
	localparam logic [5:0] R_64       = 6'd32;
	localparam logic [5:0] R_WDISP16  = 6'd40;
	localparam logic [5:0] R_WDISP19  = 6'd41;
	localparam logic [5:0] R_7        = 6'd43;
	localparam logic [5:0] R_5        = 6'd44;
	localparam logic [5:0] R_6        = 6'd45;
	localparam logic [5:0] R_TOP_CODE = 6'd63;

	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 8;
	localparam int HoldCycles = 150;

	typedef struct packed {
		logic [2:0] unit_bytes;
		logic [4:0] flags;
		logic [3:0] shift;
		logic [4:0] width;
	} reloc_info_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	srfp_pkg::in_t  in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	srfp_pkg::out_t out_item;

	// receiver hold-off for the backpressure test, driven from its own process
	logic hold_rx = 1'b0;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int fail_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int cycle_count = 0;
	int status_tally [8];

	srfp_pkg::out_t expected_patches [$];

	sparc_relocation_field_patch i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit; a hang anywhere ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// Descriptor per relocation type: unit size, flags, shift, field width.
	// Anything not listed (NONE, COPY, JMP_SLOT, V9 types, beyond the table) has no unit.
	function automatic reloc_info_t reloc_info(input logic [5:0] rtype);
		reloc_info_t d;
		unique case (rtype)
			R_8:        d = '{srfp_pkg::UNIT_BYTE, srfp_pkg::F_VER, 4'd0, 5'd0};
			R_16:       d = '{srfp_pkg::UNIT_HALF, srfp_pkg::F_VER, 4'd0, 5'd0};
			R_32:       d = '{srfp_pkg::UNIT_WORD, srfp_pkg::F_VER, 4'd0, 5'd0};
			R_DISP8:    d = '{srfp_pkg::UNIT_BYTE,
					srfp_pkg::F_VER | srfp_pkg::F_SIGN, 4'd0, 5'd0};
			R_DISP16:   d = '{srfp_pkg::UNIT_HALF,
					srfp_pkg::F_VER | srfp_pkg::F_SIGN, 4'd0, 5'd0};
			R_DISP32:   d = '{srfp_pkg::UNIT_WORD,
					srfp_pkg::F_VER | srfp_pkg::F_SIGN, 4'd0, 5'd0};
			R_WDISP30:  d = '{srfp_pkg::UNIT_WORD,
					srfp_pkg::F_VER | srfp_pkg::F_SIGN, 4'd2, 5'd30};
			R_WDISP22:  d = '{srfp_pkg::UNIT_WORD,
					srfp_pkg::F_VER | srfp_pkg::F_SIGN, 4'd2, 5'd22};
			R_HI22:     d = '{srfp_pkg::UNIT_WORD, 5'd0, 4'd10, 5'd22};
			R_22:       d = '{srfp_pkg::UNIT_WORD, srfp_pkg::F_VER, 4'd0, 5'd22};
			R_13:       d = '{srfp_pkg::UNIT_WORD,
					srfp_pkg::F_VER | srfp_pkg::F_SIGN, 4'd0, 5'd13};
			R_LO10:     d = '{srfp_pkg::UNIT_WORD,
					srfp_pkg::F_SIGN | srfp_pkg::F_LO10, 4'd0, 5'd13};
			R_GOT10:    d = '{srfp_pkg::UNIT_WORD,
					srfp_pkg::F_SIGN | srfp_pkg::F_LO10, 4'd0, 5'd13};
			R_GOT13:    d = '{srfp_pkg::UNIT_WORD,
					srfp_pkg::F_VER | srfp_pkg::F_SIGN, 4'd0, 5'd13};
			R_GOT22:    d = '{srfp_pkg::UNIT_WORD, 5'd0, 4'd10, 5'd22};
			R_PC10:     d = '{srfp_pkg::UNIT_WORD,
					srfp_pkg::F_SIGN | srfp_pkg::F_LO10, 4'd0, 5'd13};
			R_PC22:     d = '{srfp_pkg::UNIT_WORD,
					srfp_pkg::F_VER | srfp_pkg::F_SIGN, 4'd10, 5'd22};
			R_WPLT30:   d = '{srfp_pkg::UNIT_WORD,
					srfp_pkg::F_VER | srfp_pkg::F_SIGN, 4'd2, 5'd30};
			R_GLOB_DAT: d = '{srfp_pkg::UNIT_WORD, 5'd0, 4'd0, 5'd0};
			R_RELATIVE: d = '{srfp_pkg::UNIT_WORD, 5'd0, 4'd0, 5'd0};
			R_UA32:     d = '{srfp_pkg::UNIT_WORD, srfp_pkg::F_UNAL, 4'd0, 5'd0};
			R_PLT32:    d = '{srfp_pkg::UNIT_WORD, srfp_pkg::F_VER, 4'd0, 5'd0};
			R_HIPLT22:  d = '{srfp_pkg::UNIT_WORD, 5'd0, 4'd10, 5'd22};
			R_LOPLT10:  d = '{srfp_pkg::UNIT_WORD, srfp_pkg::F_LO10, 4'd0, 5'd13};
			R_PCPLT32:  d = '{srfp_pkg::UNIT_WORD, srfp_pkg::F_VER, 4'd0, 5'd0};
			R_PCPLT22:  d = '{srfp_pkg::UNIT_WORD, srfp_pkg::F_VER, 4'd10, 5'd22};
			R_PCPLT10:  d = '{srfp_pkg::UNIT_WORD,
					srfp_pkg::F_VER | srfp_pkg::F_LO10, 4'd0, 5'd12};
			R_10:       d = '{srfp_pkg::UNIT_WORD,
					srfp_pkg::F_VER | srfp_pkg::F_SIGN, 4'd0, 5'd10};
			R_11:       d = '{srfp_pkg::UNIT_WORD,
					srfp_pkg::F_VER | srfp_pkg::F_SIGN, 4'd0, 5'd11};
			R_WDISP16:  d = '{srfp_pkg::UNIT_WORD,
					srfp_pkg::F_VER | srfp_pkg::F_SIGN | srfp_pkg::F_WD16, 4'd2, 5'd16};
			R_WDISP19:  d = '{srfp_pkg::UNIT_WORD,
					srfp_pkg::F_VER | srfp_pkg::F_SIGN, 4'd2, 5'd19};
			R_7:        d = '{srfp_pkg::UNIT_WORD, 5'd0, 4'd0, 5'd7};
			R_5:        d = '{srfp_pkg::UNIT_WORD, 5'd0, 4'd0, 5'd5};
			R_6:        d = '{srfp_pkg::UNIT_WORD, 5'd0, 4'd0, 5'd6};
			default:    d = '{srfp_pkg::UNIT_NONE, 5'd0, 4'd0, 5'd0};
		endcase
		return d;
	endfunction

	// Expected result of one relocation. On any error the unit comes back
	// untouched and shifted_value carries add_value unshifted.
	function automatic srfp_pkg::out_t predict_patch(input srfp_pkg::in_t it);
		reloc_info_t d;
		srfp_pkg::word_t unit_m, unit, keep, fld, smask, fmask, core, half;
		logic [2:0] st;
		srfp_pkg::out_t r;
		d = reloc_info(it.reloc_type);
		if (d.unit_bytes == srfp_pkg::UNIT_BYTE) begin
			unit_m = 32'h0000_00ff;
		end else if (d.unit_bytes == srfp_pkg::UNIT_HALF) begin
			unit_m = 32'h0000_ffff;
		end else begin
			unit_m = '1;
		end
		unit = it.place_word & unit_m;
		r.patched_word = unit;
		r.shifted_value = it.add_value;
		st = srfp_pkg::ST_OK;
		if (d.unit_bytes == srfp_pkg::UNIT_NONE) begin
			st = srfp_pkg::ST_UNIMPL;
		end else if ((d.flags & srfp_pkg::F_UNAL) == '0 &&
				((d.unit_bytes == srfp_pkg::UNIT_HALF && it.place_addr_low[0]) ||
				(d.unit_bytes == srfp_pkg::UNIT_WORD && it.place_addr_low != 2'd0))) begin
			st = srfp_pkg::ST_ALIGN;
		end
		if (st != srfp_pkg::ST_OK) begin
			r.status = st;
			return r;
		end

		smask = (d.width == 5'd0) ? '0 : (32'd1 << d.width) - 32'd1;
		fmask = ((d.flags & srfp_pkg::F_SIGN) != '0 && smask != '0) ?
				(32'd1 << (d.width - 5'd1)) - 32'd1 : smask;
		keep = unit;
		if (smask != '0) begin
			// WDISP16 gathers bits 21:20 and 13:0 into one 16-bit field
			if ((d.flags & srfp_pkg::F_WD16) != '0) begin
				fld = ((unit & srfp_pkg::Wd16HiMask) >> 6) | (unit & srfp_pkg::Wd16LoMask);
				keep = unit & srfp_pkg::Wd16KeepMask;
			end else begin
				fld = unit & smask;
				keep = unit & ~smask;
			end
			if ((d.flags & srfp_pkg::F_SIGN) != '0 && (fld & smask & ~fmask) != '0) begin
				fld = fld | ~smask;
			end
		end else begin
			fld = unit;
		end

		fld = (fld << d.shift) + it.add_value;
		core = it.add_value;
		if (d.shift != 4'd0) begin
			if (d.shift == 4'd2 && (fld & srfp_pkg::LowTwoMask) != '0) begin
				r.status = srfp_pkg::ST_LOOSE;
				return r;
			end
			fld = srfp_pkg::word_t'($signed(fld) >>> d.shift);
			core = it.add_value >> d.shift;
		end

		if ((d.flags & srfp_pkg::F_LO10) != '0) begin
			fld = fld & srfp_pkg::Lo10Mask;
		end

		if ((d.flags & srfp_pkg::F_VER) != '0 && smask != '0) begin
			if ((d.flags & srfp_pkg::F_SIGN) != '0) begin
				half = 32'd1 << (d.width - 5'd1);
				st = (srfp_pkg::word_t'(fld + half) > smask) ? srfp_pkg::ST_NOFIT
						: srfp_pkg::ST_OK;
			end else begin
				st = ((fld & smask) != fld) ? srfp_pkg::ST_NOFIT : srfp_pkg::ST_OK;
			end
			if (st != srfp_pkg::ST_OK) begin
				r.status = st;
				return r;
			end
		end

		if (smask != '0) begin
			if ((d.flags & srfp_pkg::F_WD16) != '0) begin
				fld = ((fld & srfp_pkg::Wd16TopMask) << 6) | (fld & srfp_pkg::Wd16LoMask);
			end else begin
				fld = fld & smask;
			end
			fld = fld | keep;
		end

		r.patched_word = fld & unit_m;
		r.shifted_value = core;
		r.status = srfp_pkg::ST_OK;
		return r;
	endfunction

	function automatic srfp_pkg::in_t make_reloc(input logic [5:0] rtype,
			input srfp_pkg::word_t word, input logic [1:0] alow,
			input srfp_pkg::word_t val);
		srfp_pkg::in_t it;
		it.reloc_type = rtype;
		it.place_word = word;
		it.place_addr_low = alow;
		it.add_value = val;
		return it;
	endfunction

	// Mostly well-formed relocations: a table type, an aligned place and an
	// addend of modest size, often word aligned so shifted types get past the
	// low-bit check. The rest are full-range noise.
	function automatic srfp_pkg::in_t random_reloc();
		srfp_pkg::in_t it;
		int nbits;
		srfp_pkg::word_t val;
		it.reloc_type = ($urandom_range(99) < 85)
				? 6'($urandom_range(srfp_pkg::NumTypes - 1)) : 6'($urandom_range(63));
		it.place_word = $urandom;
		it.place_addr_low = ($urandom_range(99) < 80) ? 2'd0 : 2'($urandom_range(3));
		if ($urandom_range(99) < 12) begin
			val = $urandom;
		end else begin
			nbits = $urandom_range(31, 1);
			val = $urandom & ((32'd1 << nbits) - 32'd1);
			if ($urandom_range(1) == 1) begin
				val = -val;
			end
			if ($urandom_range(3) != 0) begin
				val = val & ~srfp_pkg::LowTwoMask;
			end
		end
		it.add_value = val;
		return it;
	endfunction

	// Send one item; valid stays up across back-to-back items and only drops
	// during a random idle gap.
	task automatic send_reloc(input srfp_pkg::in_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		expected_patches.push_back(predict_patch(it));
		items_sent++;
	endtask

	task automatic check_result(input srfp_pkg::out_t got);
		srfp_pkg::out_t want;
		if (expected_patches.size() == 0) begin
			$error("result with nothing expected: %h", got);
			fail_count++;
		end else begin
			want = expected_patches.pop_front();
			results_checked++;
			status_tally[want.status]++;
			if (got.patched_word !== want.patched_word) begin
				$error("patched_word: expected %h, got %h", want.patched_word,
						got.patched_word);
				fail_count++;
			end
			if (got.shifted_value !== want.shifted_value) begin
				$error("shifted_value: expected %h, got %h", want.shifted_value,
						got.shifted_value);
				fail_count++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				fail_count++;
			end
		end
	endtask

	// Result side: check what was taken at this edge, then pick ready for the next.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			check_result(out_item);
		end
		out_ready <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);
	end

	// Each error path and corner of the field logic, once.
	task automatic test_special_cases();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		// unimplemented types, inside and beyond the table
		send_reloc(make_reloc(R_NONE, '1, 2'd0, '1));
		send_reloc(make_reloc(R_COPY, 32'h1234_5678, 2'd0, 32'd4));
		send_reloc(make_reloc(R_JMP_SLOT, 32'h8000_0000, 2'd0, 32'd0));
		send_reloc(make_reloc(R_64, '0, 2'd3, '1));
		send_reloc(make_reloc(6'(srfp_pkg::NumTypes), 32'hdead_beef, 2'd0, 32'd1));
		send_reloc(make_reloc(R_TOP_CODE, '1, 2'd3, '1));
		// alignment: half needs bit 0 clear, word needs both clear
		send_reloc(make_reloc(R_16, 32'hffff_1234, 2'd1, 32'd1));
		send_reloc(make_reloc(R_16, 32'hffff_fffe, 2'd2, 32'd1));
		send_reloc(make_reloc(R_32, 32'h0000_0010, 2'd2, 32'd1));
		// zero-width field: the whole unit plus the addend, wrapping
		send_reloc(make_reloc(R_32, '1, 2'd0, 32'd1));
		// byte units and UA32 skip the alignment check
		send_reloc(make_reloc(R_8, 32'hffff_ff80, 2'd3, 32'h0000_007f));
		send_reloc(make_reloc(R_UA32, 32'h0102_0304, 2'd3, 32'h1000_0000));
		// loose low bits on a shift-2 type, then a field at -1 plus one word landing on zero
		send_reloc(make_reloc(R_WDISP30, 32'h4000_0000, 2'd0, 32'd1));
		send_reloc(make_reloc(R_WDISP30, 32'h7fff_ffff, 2'd0, 32'd4));
		// signed fit: field at -1 moved back, then one past the positive limit
		send_reloc(make_reloc(R_WDISP22, 32'h003f_ffff, 2'd0, 32'hffff_fff8));
		send_reloc(make_reloc(R_WDISP22, 32'h001f_ffff, 2'd0, 32'd4));
		// unsigned fit: largest value, then one too large
		send_reloc(make_reloc(R_22, 32'hffc0_0000, 2'd0, 32'h003f_ffff));
		send_reloc(make_reloc(R_22, '0, 2'd0, 32'h0040_0000));
		// split WDISP16 field: sign taken from bit 21, then -1 plus two words
		send_reloc(make_reloc(R_WDISP16, 32'h0020_0000, 2'd0, 32'd0));
		send_reloc(make_reloc(R_WDISP16, 32'h0030_3fff, 2'd0, 32'd8));
		// LO10 masking, shift-10 unverified then verified, signed 13-bit overflow, unverified 5-bit field
		send_reloc(make_reloc(R_LO10, '1, 2'd0, 32'hffff_fc00));
		send_reloc(make_reloc(R_HI22, '0, 2'd0, '1));
		send_reloc(make_reloc(R_PC22, 32'h0000_0000, 2'd0, 32'h8000_0000));
		send_reloc(make_reloc(R_13, '0, 2'd0, 32'h0000_1000));
		send_reloc(make_reloc(R_5, '1, 2'd0, '1));
	endtask

	// Random relocations under one idling pattern.
	task automatic test_random_mix(input int idle_pct, input int stall_pct, input int count);
		tx_idle_pct = idle_pct;
		rx_stall_pct = stall_pct;
		repeat (count) begin
			send_reloc(random_reloc());
		end
	endtask

	// The receiver stops for a long stretch while the sender keeps offering,
	// so the internal queue fills and the input side must stall.
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		fork
			begin
				hold_rx <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				hold_rx <= 1'b0;
			end
			begin
				repeat (24) begin
					send_reloc(random_reloc());
				end
			end
		join
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_random_mix(0, 0, 95);
		test_random_mix(78, 0, 95);
		test_random_mix(0, 78, 95);
		test_backpressure();
		test_random_mix(17, 17, 95);

		in_valid <= 1'b0;
		while (expected_patches.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d relocations, checked %0d results in %0d cycles.",
				items_sent, results_checked, cycle_count);
		$display("Status seen: ok %0d, unimpl %0d, misaligned %0d, loose %0d, no fit %0d.",
				status_tally[srfp_pkg::ST_OK], status_tally[srfp_pkg::ST_UNIMPL],
				status_tally[srfp_pkg::ST_ALIGN], status_tally[srfp_pkg::ST_LOOSE],
				status_tally[srfp_pkg::ST_NOFIT]);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
